FILE: hw/rtl/dq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dq_pkg
// shared types and constants of the double-ended queue
// ---------------------------------------------------------------------------
package dq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int CNT_W        = 7;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_LIST       = 3'd2;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [2:0] CMD_POP_BACK   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] item_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         element_count;
    logic                     last;
  } out_item_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_BACK,
    CELL_POP,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [DATA_W-1:0] value;
  } dq_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LIST,
    S_SEEK
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dq_cell
// one storage cell of the queue chain, trades data with its neighbors
// ---------------------------------------------------------------------------
module dq_cell (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire dq_pkg::dq_ctrl_t                 ctrl,
  input  wire logic signed [dq_pkg::DATA_W-1:0] left_data,
  input  wire logic                             left_valid,
  input  wire logic signed [dq_pkg::DATA_W-1:0] right_data,
  input  wire logic                             right_valid,
  input  wire logic signed [dq_pkg::DATA_W-1:0] wrap_data,
  output logic signed [dq_pkg::DATA_W-1:0]      data_r,
  output logic                                  valid_r
);
  import dq_pkg::*;

  logic signed [DATA_W-1:0] data_nxt;
  logic                     valid_nxt;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    case (ctrl.op)
      CELL_PUSH_FRONT: begin
        data_nxt  = left_data;
        valid_nxt = left_valid;
      end
      CELL_PUSH_BACK: begin
        if (!valid_r && left_valid) begin
          data_nxt  = ctrl.value;
          valid_nxt = 1'b1;
        end
      end
      CELL_POP: begin
        data_nxt  = right_data;
        valid_nxt = right_valid;
      end
      CELL_ROTATE: begin
        if (valid_r) begin
          data_nxt = right_valid ? right_data : wrap_data;
        end
      end
      default: begin
        data_nxt  = data_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/double_ended_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// double_ended_queue
// bounded double-ended queue of signed 32-bit values in a chain of cells
// ---------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low. Results
// leave on out_result, one per cycle, flagged by out_strobe; the receiver
// cannot stall, so every flagged cycle is one delivered result.
// Elements sit packed from the first cell (front) toward the back of the
// chain. Push front shifts the chain back by one, push back loads the first
// free cell, pop front shifts the chain forward: each gives its result in
// the cycle after the transaction, one command per cycle.
// A listing of n elements rotates the occupied cells once per cycle and
// gives n results on consecutive cycles, each registered from the listing
// state; busy stays high while listing.
// Pop back rotates the occupied cells n-1 times to bring the back element
// to the front, then pops it; busy stays high through the rotations and
// the pop, whose result is registered. Errors (empty, full) answer in
// the cycle after the transaction. Unknown command codes give no result.
// Reset empties the queue at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
module double_ended_queue #(
  parameter int CAPACITY = dq_pkg::CAPACITY_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire dq_pkg::in_item_t in_item,
  output logic                  out_strobe,
  output dq_pkg::out_item_t     out_result
);
  import dq_pkg::*;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  out_item_t        out_r, out_nxt;
  dq_ctrl_t         ctrl;

  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]      cell_valid;

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_result = out_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rem_nxt        = rem_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    ctrl.op        = CELL_HOLD;
    ctrl.value     = in_item.value;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_item.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              out_strobe_nxt = 1'b1;
              out_nxt.last   = 1'b1;
              if (count_r >= CAP_CNT) begin
                out_nxt.item_value    = '0;
                out_nxt.status        = ST_FULL;
                out_nxt.element_count = count_r;
              end else begin
                ctrl.op = (in_item.command == CMD_PUSH_FRONT) ? CELL_PUSH_FRONT
                                                              : CELL_PUSH_BACK;
                count_nxt             = count_r + 1'b1;
                out_nxt.item_value    = in_item.value;
                out_nxt.status        = ST_OK;
                out_nxt.element_count = count_r + 1'b1;
              end
            end
            CMD_LIST, CMD_POP_FRONT, CMD_POP_BACK: begin
              if (count_r == '0) begin
                out_strobe_nxt        = 1'b1;
                out_nxt.item_value    = '0;
                out_nxt.status        = ST_EMPTY;
                out_nxt.element_count = '0;
                out_nxt.last          = 1'b1;
              end else if (in_item.command == CMD_LIST) begin
                state_nxt = S_LIST;
                rem_nxt   = count_r;
              end else if (in_item.command == CMD_POP_BACK) begin
                state_nxt = S_SEEK;
                rem_nxt   = count_r - 1'b1;
              end else begin
                ctrl.op               = CELL_POP;
                count_nxt             = count_r - 1'b1;
                out_strobe_nxt        = 1'b1;
                out_nxt.item_value    = cell_data[0];
                out_nxt.status        = ST_OK;
                out_nxt.element_count = count_r - 1'b1;
                out_nxt.last          = 1'b1;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_LIST: begin
        ctrl.op               = CELL_ROTATE;
        rem_nxt               = rem_r - 1'b1;
        out_strobe_nxt        = 1'b1;
        out_nxt.item_value    = cell_data[0];
        out_nxt.status        = ST_OK;
        out_nxt.element_count = count_r;
        out_nxt.last          = (rem_r == CNT_W'(1));
        if (rem_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_SEEK: begin
        if (rem_r == '0) begin
          ctrl.op               = CELL_POP;
          count_nxt             = count_r - 1'b1;
          out_strobe_nxt        = 1'b1;
          out_nxt.item_value    = cell_data[0];
          out_nxt.status        = ST_OK;
          out_nxt.element_count = count_r - 1'b1;
          out_nxt.last          = 1'b1;
          state_nxt             = S_IDLE;
        end else begin
          ctrl.op = CELL_ROTATE;
          rem_nxt = rem_r - 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_data;
    logic                     left_valid;
    logic signed [DATA_W-1:0] right_data;
    logic                     right_valid;

    if (i == 0) begin : g_first
      assign left_data  = in_item.value;
      assign left_valid = 1'b1;
    end else begin : g_mid_left
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_final
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_right
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end

    dq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .left_data  (left_data),
      .left_valid (left_valid),
      .right_data (right_data),
      .right_valid(right_valid),
      .wrap_data  (cell_data[0]),
      .data_r     (cell_data[i]),
      .valid_r    (cell_valid[i])
    );
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("element count above capacity");

  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count_r))
    else $error("cell occupancy disagrees with element count");

  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("occupied cells not packed at the front");

  a_list_stream: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LIST |=> out_strobe_r)
    else $error("listing cycle gave no result");

  a_push_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.command == CMD_PUSH_FRONT ||
     in_item.command == CMD_PUSH_BACK)) |=> (out_strobe_r && out_r.last))
    else $error("push transaction gave no final result");
`endif

endmodule

`default_nettype wire
